/* sv/slfp_pkg.sv */
package slfp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_RETRY = 2'd2;

    // Stream characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field name lengths
    localparam logic [2:0] DATA_LEN  = 3'd4;
    localparam logic [2:0] RETRY_LEN = 3'd5;
    localparam logic [2:0] NAME_POS_MAX = 3'd7;

    // Largest retry value that fits a signed 32-bit int
    localparam logic [34:0] RETRY_TOP = 35'h0_7FFF_FFFF;

    // Output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [30:0] retry_value;
    } result_t;

    // Letters of "data"
    function automatic logic [7:0] data_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h64;
            2'd1:    c = 8'h61;
            2'd2:    c = 8'h74;
            default: c = 8'h61;
        endcase
        return c;
    endfunction

    // Letters of "retry"
    function automatic logic [7:0] retry_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h72;
            3'd4:    c = 8'h79;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* sv/slfp_channels.sv */
// Input byte channel
interface slfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel
interface slfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [30:0] retry_value;

    modport source (output valid, output kind, output out_byte, output retry_value,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input retry_value,
                    output ready);
endinterface

/* sv/sse_line_field_parser.sv */
// Server-sent-events line parser. Bytes of the event stream enter on in_ch, one
// request per cycle; each byte is decoded in the cycle it is accepted and its
// results (none, one or two) are written into a four-entry result queue that
// drives out_ch. Data value bytes are forwarded as they arrive, followed by an
// end marker at the newline; a retry line with a positive value in range yields
// that interval at its newline. The sustained rate is one byte per cycle while
// the sink takes one result per cycle; in_ch.ready drops when fewer than two
// queue slots are free, so a byte that releases a held carriage return (two
// results) can stall the input under a steady stream of results.
module sse_line_field_parser
    import slfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    slfp_in_if.sink   in_ch,
    slfp_out_if.source out_ch
);

    typedef enum logic [2:0] {
        PH_NAME,
        PH_DATA_FIRST,
        PH_DATA,
        PH_RETRY,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  name_pos_reg, name_pos_next;
    logic        cand_data_reg, cand_data_next;
    logic        cand_retry_reg, cand_retry_next;
    logic        held_cr_reg, held_cr_next;
    logic [30:0] acc_reg, acc_next;
    logic        f_sign_reg, f_sign_next;
    logic        f_neg_reg, f_neg_next;
    logic        f_digit_reg, f_digit_next;
    logic        f_ovf_reg, f_ovf_next;
    logic        f_stop_reg, f_stop_next;

    result_t     queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    result_t     res_a, res_b;
    logic [1:0]  n_res;
    logic [7:0]  b;
    logic        in_take, out_take;
    logic        is_ws, is_digit;
    logic [34:0] acc_times_ten;

    assign b        = in_ch.in_byte;
    assign in_take  = in_ch.valid && in_ch.ready;
    assign out_take = out_ch.valid && out_ch.ready;

    assign is_ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                   (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    // Multiply by ten as two shifts, then add the digit
    assign acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                         + {31'd0, b[3:0] - CH_ZERO[3:0]};

    // Decode one byte: next line state and its results
    always_comb
    begin
        phase_next      = phase_reg;
        name_pos_next   = name_pos_reg;
        cand_data_next  = cand_data_reg;
        cand_retry_next = cand_retry_reg;
        held_cr_next    = held_cr_reg;
        acc_next        = acc_reg;
        f_sign_next     = f_sign_reg;
        f_neg_next      = f_neg_reg;
        f_digit_next    = f_digit_reg;
        f_ovf_next      = f_ovf_reg;
        f_stop_next     = f_stop_reg;
        res_a           = '{kind: KIND_DATA, out_byte: b, retry_value: 31'd0};
        res_b           = '{kind: KIND_DATA, out_byte: b, retry_value: 31'd0};
        n_res           = 2'd0;

        if (b == CH_LF)
        begin
            // End of line: emit what the line gives, then start afresh
            if (phase_reg == PH_DATA_FIRST || phase_reg == PH_DATA)
            begin
                res_a = '{kind: KIND_END, out_byte: 8'd0, retry_value: 31'd0};
                n_res = 2'd1;
            end
            else if (phase_reg == PH_RETRY && f_digit_reg && !f_neg_reg && !f_ovf_reg &&
                     acc_reg != 31'd0)
            begin
                res_a = '{kind: KIND_RETRY, out_byte: 8'd0, retry_value: acc_reg};
                n_res = 2'd1;
            end
            phase_next      = PH_NAME;
            name_pos_next   = 3'd0;
            cand_data_next  = 1'b1;
            cand_retry_next = 1'b1;
            held_cr_next    = 1'b0;
            acc_next        = 31'd0;
            f_sign_next     = 1'b0;
            f_neg_next      = 1'b0;
            f_digit_next    = 1'b0;
            f_ovf_next      = 1'b0;
            f_stop_next     = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_NAME:
                begin
                    if (b == CH_COLON)
                    begin
                        if (name_pos_reg == DATA_LEN && cand_data_reg)
                            phase_next = PH_DATA_FIRST;
                        else if (name_pos_reg == RETRY_LEN && cand_retry_reg)
                            phase_next = PH_RETRY;
                        else
                            phase_next = PH_SKIP;
                    end
                    else
                    begin
                        // Narrow the name candidates letter by letter
                        if (name_pos_reg >= DATA_LEN || data_char(name_pos_reg[1:0]) != b)
                            cand_data_next = 1'b0;
                        if (name_pos_reg >= RETRY_LEN || retry_char(name_pos_reg) != b)
                            cand_retry_next = 1'b0;
                        if (name_pos_reg < NAME_POS_MAX)
                            name_pos_next = name_pos_reg + 3'd1;
                    end
                end
                PH_DATA_FIRST:
                begin
                    // Drop one leading space
                    phase_next = PH_DATA;
                    if (b == CH_CR)
                        held_cr_next = 1'b1;
                    else if (b != CH_SPACE)
                        n_res = 2'd1;
                end
                PH_DATA:
                begin
                    // Release a held CR ahead of this byte
                    if (held_cr_reg)
                    begin
                        res_a.out_byte = CH_CR;
                        if (b == CH_CR)
                        begin
                            held_cr_next = 1'b1;
                            n_res        = 2'd1;
                        end
                        else
                        begin
                            held_cr_next = 1'b0;
                            n_res        = 2'd2;
                        end
                    end
                    else if (b == CH_CR)
                        held_cr_next = 1'b1;
                    else
                        n_res = 2'd1;
                end
                PH_RETRY:
                begin
                    if (!f_stop_reg)
                    begin
                        if (!f_sign_reg && !f_digit_reg && is_ws)
                        begin
                            // skip leading whitespace
                        end
                        else if (!f_sign_reg && !f_digit_reg &&
                                 (b == CH_PLUS || b == CH_MINUS))
                        begin
                            f_sign_next = 1'b1;
                            f_neg_next  = (b == CH_MINUS);
                        end
                        else if (is_digit)
                        begin
                            f_digit_next = 1'b1;
                            if (!f_ovf_reg)
                            begin
                                if (acc_times_ten > RETRY_TOP)
                                    f_ovf_next = 1'b1;
                                else
                                    acc_next = acc_times_ten[30:0];
                            end
                        end
                        else
                            f_stop_next = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_SKIP;
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    // Hold line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_NAME;
            name_pos_reg   <= 3'd0;
            cand_data_reg  <= 1'b1;
            cand_retry_reg <= 1'b1;
            held_cr_reg    <= 1'b0;
            acc_reg        <= 31'd0;
            f_sign_reg     <= 1'b0;
            f_neg_reg      <= 1'b0;
            f_digit_reg    <= 1'b0;
            f_ovf_reg      <= 1'b0;
            f_stop_reg     <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg      <= phase_next;
            name_pos_reg   <= name_pos_next;
            cand_data_reg  <= cand_data_next;
            cand_retry_reg <= cand_retry_next;
            held_cr_reg    <= held_cr_next;
            acc_reg        <= acc_next;
            f_sign_reg     <= f_sign_next;
            f_neg_reg      <= f_neg_next;
            f_digit_reg    <= f_digit_next;
            f_ovf_reg      <= f_ovf_next;
            f_stop_reg     <= f_stop_next;
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_take)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_res);
            if (out_take)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + (in_take ? QCNT_W'(n_res) : QCNT_W'(0))
                       - (out_take ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    // Write results into the queue
    always_ff @(posedge clk)
    begin
        if (in_take && n_res != 2'd0)
            queue_reg[wr_ptr_reg] <= res_a;
        if (in_take && n_res == 2'd2)
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res_b;
    end

    // Take a byte only when at least two slots are free
    assign in_ch.ready        = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_ch.valid       = (count_reg != '0);
    assign out_ch.kind        = queue_reg[rd_ptr_reg].kind;
    assign out_ch.out_byte    = queue_reg[rd_ptr_reg].out_byte;
    assign out_ch.retry_value = queue_reg[rd_ptr_reg].retry_value;

endmodule

/* sv/slfp_checker.sv */
module slfp_checker
    import slfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  out_byte,
    input logic [30:0] retry_value
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte) &&
            $stable(retry_value))
        else $error("stalled result changed");

    // Kind is one of the three result kinds
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_DATA || kind == KIND_END || kind == KIND_RETRY))
        else $error("illegal result kind");

    // Byte field is zero outside data results
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> out_byte == 8'd0)
        else $error("byte set on non-data result");

    // Retry field is zero outside retry results
    a_retry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_RETRY |-> retry_value == 31'd0)
        else $error("retry value set on non-retry result");

    // A retry result always carries a positive interval
    a_retry_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RETRY |-> retry_value != 31'd0)
        else $error("zero retry interval emitted");

endmodule

bind sse_line_field_parser slfp_checker u_slfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .kind        (out_ch.kind),
    .out_byte    (out_ch.out_byte),
    .retry_value (out_ch.retry_value)
);
